// File: rtl/core/cbf_pkg.sv
// cbf_pkg: shared constants and types for the comment blanking filter.
// No dependencies; used by cbf_scan, cbf_outq and comment_blanking_filter.
package cbf_pkg;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  // output queue depth and its pointer/count widths
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one cleaned output word
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } word_t;

  // words produced by one input word: 0, 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    word_t      w0;
    word_t      w1;
  } res_t;

endpackage

// File: rtl/core/comment_blanking_filter.sv
// comment_blanking_filter: blanks C/C++ comments in a byte stream, same length.
// Depends on cbf_pkg, cbf_scan, cbf_outq.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid in_ready in_byte      | in
//           | in_last                        |
//   output  | out_valid out_ready out_byte   | out
//           | out_last                       |
//
// One input word is decoded in the cycle it is accepted; its 0..2 output words
// are registered into a four-entry queue and leave one per cycle unless stalled.
// Input is taken every cycle while the queue has two free slots; a held slash
// followed by a byte gives two output words, which the single output port
// drains at one word per cycle while out_ready is high. Synchronous active-low
// reset empties the queue and returns the scanner to ordinary text. Stalls on
// out_ready back up the queue and then drop in_ready.
module comment_blanking_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  cbf_pkg::res_t  res;
  cbf_pkg::word_t out_word;
  logic           fire;

  assign fire = in_valid && in_ready;

  cbf_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .data  (in_byte),
    .last  (in_last),
    .res   (res)
  );

  cbf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_byte = out_word.data;
  assign out_last = out_word.last;

endmodule

// File: rtl/core/cbf_scan.sv
// cbf_scan: comment scanner state and per-word decode.
// Depends on cbf_pkg.
module cbf_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data,
  input  logic              last,
  output cbf_pkg::res_t     res
);

  logic [1:0] mode_r, mode_nxt;
  logic       slash_r, slash_nxt;
  logic       star_r, star_nxt;
  logic       halt_r, halt_nxt;
  logic [1:0] cnt;
  logic [7:0] b0, b1;

  always_comb begin
    cnt       = 2'd0;
    b0        = data;
    b1        = data;
    mode_nxt  = mode_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    halt_nxt  = halt_r;
    if (halt_r) begin
      cnt = 2'd1;
    end else begin
      case (mode_r)
        cbf_pkg::MODE_LINE: begin
          cnt = 2'd1;
          if (data == cbf_pkg::CH_NUL) begin
            halt_nxt = 1'b1;
          end else if (data == cbf_pkg::CH_NEWLINE) begin
            mode_nxt = cbf_pkg::MODE_TEXT;
          end else begin
            b0 = cbf_pkg::CH_SPACE;
          end
        end
        cbf_pkg::MODE_BLOCK: begin
          cnt = 2'd1;
          if (data == cbf_pkg::CH_NUL) begin
            halt_nxt = 1'b1;
          end else if (data == cbf_pkg::CH_NEWLINE) begin
            star_nxt = 1'b0;
          end else if (data == cbf_pkg::CH_STAR) begin
            b0       = cbf_pkg::CH_SPACE;
            star_nxt = 1'b1;
          end else if (data == cbf_pkg::CH_SLASH && star_r) begin
            b0       = cbf_pkg::CH_SPACE;
            star_nxt = 1'b0;
            mode_nxt = cbf_pkg::MODE_TEXT;
          end else begin
            b0       = cbf_pkg::CH_SPACE;
            star_nxt = 1'b0;
          end
        end
        default: begin
          // ordinary text (unused code treated the same)
          if (slash_r) begin
            cnt       = 2'd2;
            slash_nxt = 1'b0;
            if (data == cbf_pkg::CH_SLASH) begin
              b0       = cbf_pkg::CH_SPACE;
              b1       = cbf_pkg::CH_SPACE;
              mode_nxt = cbf_pkg::MODE_LINE;
            end else if (data == cbf_pkg::CH_STAR) begin
              b0       = cbf_pkg::CH_SPACE;
              b1       = cbf_pkg::CH_SPACE;
              star_nxt = 1'b0;
              mode_nxt = cbf_pkg::MODE_BLOCK;
            end else begin
              b0 = cbf_pkg::CH_SLASH;
              if (data == cbf_pkg::CH_NUL) begin
                halt_nxt = 1'b1;
              end
            end
          end else if (data == cbf_pkg::CH_SLASH) begin
            if (last) begin
              cnt = 2'd1;
            end else begin
              slash_nxt = 1'b1;
            end
          end else begin
            cnt = 2'd1;
            if (data == cbf_pkg::CH_NUL) begin
              halt_nxt = 1'b1;
            end
          end
        end
      endcase
    end
    // end of text: next word starts a fresh text
    if (last) begin
      mode_nxt  = cbf_pkg::MODE_TEXT;
      slash_nxt = 1'b0;
      star_nxt  = 1'b0;
      halt_nxt  = 1'b0;
    end
  end

  always_comb begin
    res.cnt     = cnt;
    res.w0.data = b0;
    res.w0.last = last && (cnt == 2'd1);
    res.w1.data = b1;
    res.w1.last = last && (cnt == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cbf_pkg::MODE_TEXT;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
      halt_r  <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

// File: rtl/core/cbf_outq.sv
// cbf_outq: small register queue taking up to two words per cycle, giving one while out_ready is high.
// Depends on cbf_pkg.
module cbf_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cbf_pkg::res_t     res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output cbf_pkg::word_t    out_word
);

  cbf_pkg::word_t mem_r [cbf_pkg::QDEPTH];

  logic [cbf_pkg::QAW-1:0] wptr_r, wptr_nxt, wptr_p1;
  logic [cbf_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [cbf_pkg::QCW-1:0] cnt_r, cnt_nxt;
  logic [1:0]              nin;
  logic                    pop;

  assign nin     = push ? res.cnt : 2'd0;
  assign pop     = out_valid && out_ready;
  assign wptr_p1 = wptr_r + 1'b1;

  // two free slots guarantee room for the worst case of one input word
  assign room      = cnt_r <= cbf_pkg::QCW'(cbf_pkg::QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_word  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + cbf_pkg::QAW'(nin);
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + cbf_pkg::QCW'(nin) - cbf_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (nin != 2'd0) begin
      mem_r[wptr_r] <= res.w0;
    end
    if (nin == 2'd2) begin
      mem_r[wptr_p1] <= res.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: tb/tb.sv
// tb: self-checking bench for comment_blanking_filter, directed table then random texts.
// Depends on cbf_pkg and the comment_blanking_filter RTL; no files, no arguments.
module tb;

  localparam int N_RANDOM   = 550;
  localparam int QUIET_MAX  = 1000;
  localparam int HOLD_CYCLES = 80;

  // one stimulus row; typed rows carry their own expected words
  typedef struct packed {
    logic [7:0] c;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  always #10 clk = ~clk;

  comment_blanking_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // predictor state
  logic [1:0] mode       = cbf_pkg::MODE_TEXT;
  logic       slash_held = 1'b0;
  logic       star_prev  = 1'b0;
  logic       stopped    = 1'b0;

  cbf_pkg::word_t step_words[$];
  cbf_pkg::word_t expect_q[$];
  row_t           inflight_rows[$];
  logic [7:0]     text_buf[$];
  row_t           dir_rows[25];

  int   err_cnt      = 0;
  int   words_seen   = 0;
  int   quiet_cycles = 0;
  logic steady       = 1'b0;
  logic hold_rx      = 1'b0;

  function void emit_word(logic [7:0] d);
    cbf_pkg::word_t w;
    w.data = d;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  // blanks one character; fills step_words with the 0..2 words it causes
  function void blank_char(logic [7:0] c, logic fin);
    step_words.delete();
    if (stopped) begin
      emit_word(c);
    end else if (mode == cbf_pkg::MODE_LINE) begin
      if (c == cbf_pkg::CH_NUL) begin
        emit_word(c);
        stopped = 1'b1;
      end else if (c == cbf_pkg::CH_NEWLINE) begin
        emit_word(c);
        mode = cbf_pkg::MODE_TEXT;
      end else begin
        emit_word(cbf_pkg::CH_SPACE);
      end
    end else if (mode == cbf_pkg::MODE_BLOCK) begin
      if (c == cbf_pkg::CH_NUL) begin
        emit_word(c);
        stopped = 1'b1;
      end else if (c == cbf_pkg::CH_NEWLINE) begin
        emit_word(c);
        star_prev = 1'b0;
      end else if (c == cbf_pkg::CH_STAR) begin
        emit_word(cbf_pkg::CH_SPACE);
        star_prev = 1'b1;
      end else if (c == cbf_pkg::CH_SLASH && star_prev) begin
        emit_word(cbf_pkg::CH_SPACE);
        star_prev = 1'b0;
        mode = cbf_pkg::MODE_TEXT;
      end else begin
        emit_word(cbf_pkg::CH_SPACE);
        star_prev = 1'b0;
      end
    end else if (slash_held) begin
      slash_held = 1'b0;
      if (c == cbf_pkg::CH_SLASH) begin
        emit_word(cbf_pkg::CH_SPACE);
        emit_word(cbf_pkg::CH_SPACE);
        mode = cbf_pkg::MODE_LINE;
      end else if (c == cbf_pkg::CH_STAR) begin
        emit_word(cbf_pkg::CH_SPACE);
        emit_word(cbf_pkg::CH_SPACE);
        star_prev = 1'b0;
        mode = cbf_pkg::MODE_BLOCK;
      end else begin
        emit_word(cbf_pkg::CH_SLASH);
        emit_word(c);
        if (c == cbf_pkg::CH_NUL) stopped = 1'b1;
      end
    end else if (c == cbf_pkg::CH_SLASH) begin
      // a slash on the final character cannot start a comment
      if (fin) emit_word(cbf_pkg::CH_SLASH);
      else slash_held = 1'b1;
    end else begin
      emit_word(c);
      if (c == cbf_pkg::CH_NUL) stopped = 1'b1;
    end
    if (fin) begin
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      mode       = cbf_pkg::MODE_TEXT;
      slash_held = 1'b0;
      star_prev  = 1'b0;
      stopped    = 1'b0;
    end
  endfunction

  // compare outputs, predict accepted inputs, watchdog
  always @(posedge clk) begin : monitor
    row_t           r;
    cbf_pkg::word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (expect_q.size() == 0) begin
          $error("unexpected word: out_byte=%h out_last=%b", out_byte, out_last);
          err_cnt++;
        end else begin
          want = expect_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            err_cnt++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_last);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r = inflight_rows.pop_front();
        blank_char(in_byte, in_last);
        if (r.typed) begin
          for (int i = 0; i < r.n; i++) begin
            want.data = (i == 0) ? r.e0 : r.e1;
            want.last = in_last && (i == r.n - 1);
            expect_q.push_back(want);
          end
        end else begin
          foreach (step_words[i]) expect_q.push_back(step_words[i]);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance, or after a short idle gap
  task automatic offer_word(row_t r);
    inflight_rows.push_back(r);
    in_valid <= 1'b1;
    in_byte  <= r.c;
    in_last  <= r.fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    // short gaps, rare enough to idle about a tenth of the time
    if (!steady && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expect_q.size() != 0) @(negedge clk);
  endtask

  function logic [7:0] plain_char();
    if ($urandom_range(9) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function logic [7:0] block_char();
    case ($urandom_range(4))
      0: return cbf_pkg::CH_STAR;
      1: return cbf_pkg::CH_SLASH;
      2: return cbf_pkg::CH_NEWLINE;
      default: return plain_char();
    endcase
  endfunction

  // mostly well-formed text with comments; a tenth is raw noise
  task automatic build_text();
    int len;
    int k;
    text_buf.delete();
    len = $urandom_range(1, 40);
    if ($urandom_range(99) < 10) begin
      repeat (len) text_buf.push_back(8'($urandom_range(255)));
    end else begin
      while (text_buf.size() < len) begin
        k = $urandom_range(99);
        if (k < 35) begin
          text_buf.push_back(plain_char());
        end else if (k < 50) begin
          text_buf.push_back(cbf_pkg::CH_SLASH);
          text_buf.push_back(cbf_pkg::CH_SLASH);
          repeat ($urandom_range(0, 6)) text_buf.push_back(block_char());
          if ($urandom_range(9) != 0) text_buf.push_back(cbf_pkg::CH_NEWLINE);
        end else if (k < 68) begin
          text_buf.push_back(cbf_pkg::CH_SLASH);
          text_buf.push_back(cbf_pkg::CH_STAR);
          repeat ($urandom_range(0, 8)) text_buf.push_back(block_char());
          // some block comments are left open
          if ($urandom_range(4) != 0) begin
            text_buf.push_back(cbf_pkg::CH_STAR);
            text_buf.push_back(cbf_pkg::CH_SLASH);
          end
        end else if (k < 78) begin
          text_buf.push_back(cbf_pkg::CH_SLASH);
          text_buf.push_back(plain_char());
        end else if (k < 86) begin
          text_buf.push_back(cbf_pkg::CH_NEWLINE);
        end else if (k < 92) begin
          text_buf.push_back(cbf_pkg::CH_STAR);
        end else if (k < 95) begin
          text_buf.push_back(cbf_pkg::CH_SLASH);
        end else if (k < 97) begin
          text_buf.push_back(cbf_pkg::CH_NUL);
        end else begin
          text_buf.push_back(8'($urandom_range(128, 255)));
        end
      end
    end
  endtask

  initial begin : stimulus
    row_t r;
    int   n_texts;
    int   n_rand;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    in_last  = 1'b0;
    n_texts  = 0;
    n_rand   = 0;

    // c, fin, typed, n, e0, e1
    dir_rows = '{
      '{8'h61,               1'b0, 1'b1, 2'd1, 8'h61,               8'h00},
      '{8'hFF,               1'b0, 1'b1, 2'd1, 8'hFF,               8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd2, cbf_pkg::CH_SPACE,   cbf_pkg::CH_SPACE},
      '{8'h78,               1'b0, 1'b0, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd1, cbf_pkg::CH_NEWLINE, 8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_STAR,    1'b0, 1'b1, 2'd2, cbf_pkg::CH_SPACE,   cbf_pkg::CH_SPACE},
      // opener star must not close: comment stays open
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd1, cbf_pkg::CH_SPACE,   8'h00},
      '{cbf_pkg::CH_STAR,    1'b0, 1'b0, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_NEWLINE, 1'b0, 1'b1, 2'd1, cbf_pkg::CH_NEWLINE, 8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b0, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_STAR,    1'b0, 1'b1, 2'd1, cbf_pkg::CH_SPACE,   8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd1, cbf_pkg::CH_SPACE,   8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd0, 8'h00,               8'h00},
      '{8'h71,               1'b0, 1'b1, 2'd2, cbf_pkg::CH_SLASH,   8'h71},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_NUL,     1'b0, 1'b1, 2'd2, cbf_pkg::CH_SLASH,   cbf_pkg::CH_NUL},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd1, cbf_pkg::CH_SLASH,   8'h00},
      '{cbf_pkg::CH_STAR,    1'b1, 1'b1, 2'd1, cbf_pkg::CH_STAR,    8'h00},
      '{cbf_pkg::CH_SLASH,   1'b1, 1'b1, 2'd1, cbf_pkg::CH_SLASH,   8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd0, 8'h00,               8'h00},
      '{cbf_pkg::CH_SLASH,   1'b0, 1'b1, 2'd2, cbf_pkg::CH_SPACE,   cbf_pkg::CH_SPACE},
      '{cbf_pkg::CH_NUL,     1'b0, 1'b1, 2'd1, cbf_pkg::CH_NUL,     8'h00},
      '{8'h7A,               1'b1, 1'b0, 2'd0, 8'h00,               8'h00}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer_word(dir_rows[i]);
    drain_outputs();

    while (n_rand < N_RANDOM) begin
      if (n_texts == 4) hold_rx = 1'b1;
      steady = (n_texts >= 8 && n_texts < 14);
      if (n_texts == 18) drain_outputs();
      build_text();
      foreach (text_buf[j]) begin
        r       = '0;
        r.c     = text_buf[j];
        r.fin   = (j == text_buf.size() - 1);
        offer_word(r);
        n_rand++;
      end
      n_texts++;
    end

    steady = 1'b0;
    drain_outputs();
    repeat (8) @(negedge clk);

    $display("run covered %0d directed and %0d random words in %0d random texts",
             $size(dir_rows), n_rand, n_texts);
    $display("%0d output words checked, %0d mismatches", words_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
